@@ hw/rtl/md5_pkg.sv @@
// Shared types, round constants and helper functions for the MD5 byte stream core.
package md5_pkg;

  localparam logic [1:0] FUNC_ABSORB        = 2'd0;
  localparam logic [1:0] FUNC_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] FUNC_FINISH        = 2'd2;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [31:0] K_TABLE [64] = '{
    32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
    32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
    32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
    32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
    32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
    32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
    32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
    32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
    32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
    32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
    32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
    32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
    32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
    32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
    32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
    32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
  };

  localparam logic [4:0] S_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic start;
    logic reinit;
  } md5_cmd_t;

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    begin
      r = rnd[3:0];
      case (rnd[5:4])
        2'd0: g = r;
        2'd1: g = 4'((r << 2) + r + 4'd1);
        2'd2: g = 4'((r << 1) + r + 4'd5);
        2'd3: g = 4'((r << 3) - r);
        default: g = r;
      endcase
      return g;
    end
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    begin
      t = {x, x} << s;
      return t[63:32];
    end
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ hw/rtl/md5_buf_mem.sv @@
// Block buffer: 16 x 32-bit synchronous memory, byte-lane write, registered word read.
module md5_buf_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [5:0]  waddr,
  input  logic [7:0]  wbyte,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[5:2]][{waddr[1:0], 3'b000} +: 8] <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/md5_compress.sv @@
// Round engine: one MD5 round per cycle over words fetched from the block buffer.
module md5_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  md5_pkg::md5_cmd_t    cmd,
  input  logic [31:0]          rd_word,
  output logic [3:0]           rd_addr,
  output logic                 done,
  output logic [3:0][31:0]     chain
);
  import md5_pkg::*;

  logic             running;
  logic             adding;
  logic [5:0]       rnd;
  logic [31:0]      a, b, c, d;
  logic [31:0]      f;
  logic [31:0]      b_next;
  logic [3:0][31:0] h;

  assign chain = h;
  assign rd_addr = cmd.start ? 4'd0 : msg_index(6'(rnd + 6'd1));

  always_comb begin
    case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    b_next = b + rotl32(a + f + K_TABLE[rnd] + rd_word, S_TABLE[{rnd[5:4], rnd[1:0]}]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      adding  <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
      h       <= {IV3, IV2, IV1, IV0};
    end else begin
      done <= adding && !cmd.start && !running;
      if (cmd.reinit) begin
        h <= {IV3, IV2, IV1, IV0};
      end
      if (cmd.start) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        rnd <= rnd + 6'd1;
        if (rnd == LAST_POS) begin
          running <= 1'b0;
          adding  <= 1'b1;
        end
      end else if (adding) begin
        adding <= 1'b0;
        h[0]   <= h[0] + a;
        h[1]   <= h[1] + b;
        h[2]   <= h[2] + c;
        h[3]   <= h[3] + d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
    end else if (running) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_next;
    end
  end

endmodule

@@ hw/rtl/md5_byte_stream_hash_core.sv @@
// MD5 byte stream core: beat control, padding sequencer and digest output register.
// An absorb beat writes one byte; a byte that fills a block also starts its compression.
// A finish writes the pad bytes one per cycle and compresses one or two blocks, one
// round per cycle; the digest is then registered once the output register is free.
// s_tready is high only while no byte, pad, compression or digest output work is pending.
// Synchronous reset restores the initial chaining words and clears the bit count.
module md5_byte_stream_hash_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // func[1:0], data_byte[9:2], zero[15:10]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // digest_first_half[63:0], digest_second_half[127:64]
);
  import md5_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state;
  logic [63:0]      bit_count;
  logic [5:0]       p;
  logic             fin;
  logic             pad_first;
  logic             final_blk;
  logic             out_valid;
  logic [127:0]     out_data;

  logic [1:0]       func;
  logic [7:0]       data_byte;
  logic             take;
  logic             absorb;
  logic             finreq;
  logic [5:0]       pos;
  logic             out_free;
  logic             mem_we;
  logic [5:0]       mem_waddr;
  logic [7:0]       mem_wbyte;
  logic [7:0]       pad_byte;
  logic [3:0]       rd_addr;
  logic [31:0]      rd_word;
  logic             done;
  logic [3:0][31:0] chain;
  md5_cmd_t         cmd;

  assign func      = s_tdata[1:0];
  assign data_byte = s_tdata[9:2];
  assign s_tready  = (state == ST_IDLE);
  assign take      = s_tvalid && s_tready;
  assign absorb    = take && (func == FUNC_ABSORB || func == FUNC_ABSORB_FINISH);
  assign finreq    = take && (func == FUNC_ABSORB_FINISH || func == FUNC_FINISH);
  assign pos       = bit_count[8:3];
  assign out_free  = !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (final_blk && p >= LEN_POS) begin
      pad_byte = bit_count[{p[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'd0;
    end
    mem_we    = absorb || (state == ST_PAD);
    mem_waddr = (state == ST_PAD) ? p : pos;
    mem_wbyte = (state == ST_PAD) ? pad_byte : data_byte;
    cmd.start  = (absorb && pos == LAST_POS) || (state == ST_PAD && p == LAST_POS);
    cmd.reinit = (state == ST_OUT) && out_free;
  end

  md5_buf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wbyte (mem_wbyte),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  md5_compress u_comp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_word (rd_word),
    .rd_addr (rd_addr),
    .done    (done),
    .chain   (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_count <= '0;
      p         <= '0;
      fin       <= 1'b0;
      pad_first <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (absorb) begin
            bit_count <= bit_count + 64'd8;
          end
          if (finreq) begin
            fin       <= 1'b1;
            pad_first <= 1'b1;
            final_blk <= 1'b0;
            p         <= absorb ? 6'(pos + 6'd1) : pos;
          end
          if (absorb && pos == LAST_POS) begin
            state <= ST_COMP;
          end else if (finreq) begin
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (pad_first) begin
            pad_first <= 1'b0;
            final_blk <= (p < LEN_POS);
          end
          p <= p + 6'd1;
          if (p == LAST_POS) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (done) begin
            if (!fin) begin
              state <= ST_IDLE;
            end else if (pad_first) begin
              state <= ST_PAD;
            end else if (final_blk) begin
              state <= ST_OUT;
            end else begin
              final_blk <= 1'b1;
              state     <= ST_PAD;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            bit_count <= '0;
            fin       <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_data <= {bswap32(chain[2]), bswap32(chain[3]),
                   bswap32(chain[0]), bswap32(chain[1])};
    end
  end

endmodule

@@ hw/rtl/md5_chk.sv @@
// Port-level checker for the MD5 byte stream core and its bind.
module md5_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [15:0]  s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  import md5_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("core not idle after reset");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tdata[1:0] == FUNC_ABSORB_FINISH || s_tdata[1:0] == FUNC_FINISH))
    |=> !s_tready)
    else $error("finish beat did not start padding");

  a_no_digest_while_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("digest beat without a finish");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("digest beat dropped or changed while stalled");

endmodule

bind md5_byte_stream_hash_core md5_chk u_md5_chk (.*);
